@@ hdl/rrop_pkg.sv @@
// ----------------------------------------------------------------------------
// Rounded rectangle outline points: shared package
// Widths, register codes, sequencer states, control bundle and the CORDIC
// arctangent table.
// ----------------------------------------------------------------------------
package rrop_pkg;

  localparam int MAX_QUALITY  = 4096;
  localparam int CORDIC_STEPS = 16;

  localparam int IDX_W    = $clog2(MAX_QUALITY);
  localparam int QUAL_W   = IDX_W + 1;
  localparam int COORD_W  = 24;
  localparam int DIM_W    = 23;
  localparam int ARC_W    = 16;
  localparam int COLOR_W  = 32;
  localparam int STATUS_W = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam int TURN_W     = 32;
  localparam int DIV_CNT_W  = $clog2(TURN_W);
  localparam int CSTEP_W    = $clog2(CORDIC_STEPS);
  localparam int CNT_W      = (DIV_CNT_W > CSTEP_W) ? DIV_CNT_W : CSTEP_W;
  localparam int ATAN_IDX_W = 5;

  localparam logic [30:0]        PI_HALF_Q30 = 31'd1686629713;
  localparam logic signed [31:0] GAIN_Q30    = 32'sd652032874;

  localparam logic [CFG_IDX_W-1:0] CFG_QUALITY     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_POS_X       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_POS_Y       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RECT_WIDTH  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RECT_HEIGHT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ARC_RATIO   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_FILL_COLOR  = 3'd6;

  localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_QUALITY = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_RANGE   = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SETUP,
    ST_DIV,
    ST_ANGLE,
    ST_CINIT,
    ST_CORDIC,
    ST_MULX,
    ST_MULY,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic             load;
    logic             setup;
    logic             div;
    logic             angle;
    logic             cinit;
    logic             cordic;
    logic             mulx;
    logic             muly;
    logic             fin;
    logic [CNT_W-1:0] step;
  } ctrl_t;

  typedef struct packed {
    logic [QUAL_W-1:0]  quality;
    logic [COORD_W-1:0] pos_x;
    logic [COORD_W-1:0] pos_y;
    logic [DIM_W-1:0]   rect_width;
    logic [DIM_W-1:0]   rect_height;
    logic [ARC_W-1:0]   arc_ratio;
    logic [COLOR_W-1:0] fill_color;
  } cfg_t;

  // atan(2^-i) in Q30, truncated
  function automatic logic signed [31:0] atan_q30(input logic [ATAN_IDX_W-1:0] i);
    logic signed [31:0] v;
    case (i)
      5'd0:    v = 32'sd843314856;
      5'd1:    v = 32'sd497837829;
      5'd2:    v = 32'sd263043836;
      5'd3:    v = 32'sd133525158;
      5'd4:    v = 32'sd67021686;
      5'd5:    v = 32'sd33543515;
      5'd6:    v = 32'sd16775850;
      5'd7:    v = 32'sd8388437;
      5'd8:    v = 32'sd4194282;
      5'd9:    v = 32'sd2097149;
      5'd10:   v = 32'sd1048575;
      5'd11:   v = 32'sd524287;
      5'd12:   v = 32'sd262143;
      5'd13:   v = 32'sd131071;
      5'd14:   v = 32'sd65535;
      5'd15:   v = 32'sd32767;
      5'd16:   v = 32'sd16383;
      5'd17:   v = 32'sd8191;
      5'd18:   v = 32'sd4095;
      5'd19:   v = 32'sd2047;
      5'd20:   v = 32'sd1023;
      5'd21:   v = 32'sd511;
      5'd22:   v = 32'sd255;
      5'd23:   v = 32'sd127;
      default: v = 32'sd0;
    endcase
    return v;
  endfunction

endpackage

@@ hdl/rrop_ctrl.sv @@
// ----------------------------------------------------------------------------
// Rounded rectangle outline points: sequencer
// Steps the shared datapath through setup, turn division, angle scaling,
// CORDIC rotation and the final offset products.
// ----------------------------------------------------------------------------
module rrop_ctrl import rrop_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  start,
  input  logic  setup_err,
  output logic  busy,
  output ctrl_t ctrl
);

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (start) state_nxt = ST_SETUP;
      ST_SETUP:  state_nxt = setup_err ? ST_IDLE : ST_DIV;
      ST_DIV:    if (cnt_r == CNT_W'(TURN_W - 1)) state_nxt = ST_ANGLE;
      ST_ANGLE:  state_nxt = ST_CINIT;
      ST_CINIT:  state_nxt = ST_CORDIC;
      ST_CORDIC: if (cnt_r == CNT_W'(CORDIC_STEPS - 1)) state_nxt = ST_MULX;
      ST_MULX:   state_nxt = ST_MULY;
      ST_MULY:   state_nxt = ST_FIN;
      ST_FIN:    state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    if ((state_r inside {ST_DIV, ST_CORDIC}) && state_nxt == state_r) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else begin
      cnt_nxt = '0;
    end
  end

  always_comb begin
    ctrl      = '0;
    ctrl.step = cnt_r;
    case (state_r)
      ST_IDLE:   ctrl.load   = start;
      ST_SETUP:  ctrl.setup  = 1'b1;
      ST_DIV:    ctrl.div    = 1'b1;
      ST_ANGLE:  ctrl.angle  = 1'b1;
      ST_CINIT:  ctrl.cinit  = 1'b1;
      ST_CORDIC: ctrl.cordic = 1'b1;
      ST_MULX:   ctrl.mulx   = 1'b1;
      ST_MULY:   ctrl.muly   = 1'b1;
      ST_FIN:    ctrl.fin    = 1'b1;
      default:   ctrl        = '0;
    endcase
  end

  assign busy = (state_r != ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

@@ hdl/rrop_dp.sv @@
// ----------------------------------------------------------------------------
// Rounded rectangle outline points: datapath
// Corner select, bit-serial turn divider, one shared multiplier, a shared
// shift-add CORDIC stage and the saturating point sum.
// ----------------------------------------------------------------------------
module rrop_dp import rrop_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  ctrl_t                      ctrl,
  input  cfg_t                       cfg,
  input  logic [IDX_W-1:0]           in_vertex_index,
  output logic                       setup_err,
  output logic                       out_valid,
  output logic signed [COORD_W-1:0]  out_point_x,
  output logic signed [COORD_W-1:0]  out_point_y,
  output logic [COLOR_W-1:0]         out_vertex_color,
  output logic [STATUS_W-1:0]        out_status
);

  localparam int SUM_W = 28;

  function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [SUM_W-1:0] v);
    logic signed [COORD_W-1:0] r;
    if (v > SUM_W'(8388607)) begin
      r = 24'sh7FFFFF;
    end else if (v < -SUM_W'(8388608)) begin
      r = 24'sh800000;
    end else begin
      r = v[COORD_W-1:0];
    end
    return r;
  endfunction

  logic [IDX_W-1:0]          idx_r;
  logic [1:0]                corner_r;
  logic [1:0]                quad_r;
  logic [QUAL_W-1:0]         rem_r, rem_nxt;
  logic [TURN_W-1:0]         quo_r;
  logic signed [64:0]        prod_r;
  logic [DIM_W-1:0]          radius_r;
  logic signed [31:0]        x_r, y_r, z_r;
  logic signed [COORD_W-1:0] px_r;
  logic                      out_valid_r;
  logic signed [COORD_W-1:0] out_point_x_r, out_point_y_r;
  logic [COLOR_W-1:0]        out_vertex_color_r;
  logic [STATUS_W-1:0]       out_status_r;

  // setup: status, corner, numerator
  logic [QUAL_W-1:0]   q_quarter, q_half, q_three, idx_ext, span, n_ext;
  logic [1:0]          corner;
  logic [IDX_W-1:0]    n;
  logic                err_quality, err_range;

  always_comb begin
    q_quarter   = {2'b00, cfg.quality[QUAL_W-1:2]};
    q_half      = {q_quarter[QUAL_W-2:0], 1'b0};
    q_three     = q_half + q_quarter;
    idx_ext     = {1'b0, idx_r};
    err_quality = (cfg.quality[1:0] != 2'b00);
    err_range   = (idx_ext >= cfg.quality);
    if (idx_ext >= q_three) begin
      corner = 2'd3;
    end else if (idx_ext >= q_half) begin
      corner = 2'd2;
    end else if (idx_ext >= q_quarter) begin
      corner = 2'd1;
    end else begin
      corner = 2'd0;
    end
    n     = idx_r - IDX_W'(corner);
    n_ext = {1'b0, n};
    span  = cfg.quality - QUAL_W'(4);
  end

  assign setup_err = err_quality || err_range;

  // restoring divider, one quotient bit per step
  logic [QUAL_W:0] rem2;
  logic            qbit;

  always_comb begin
    rem2    = {rem_r, 1'b0};
    qbit    = (span != '0) && (rem2 >= {1'b0, span});
    rem_nxt = qbit ? QUAL_W'(rem2 - {1'b0, span}) : rem2[QUAL_W-1:0];
  end

  // cosine / sine after quadrant fold
  logic signed [32:0] cos_v, sin_v;

  always_comb begin
    case (quad_r)
      2'd0: begin
        cos_v = 33'(x_r);
        sin_v = 33'(y_r);
      end
      2'd1: begin
        cos_v = -33'(y_r);
        sin_v = 33'(x_r);
      end
      2'd2: begin
        cos_v = -33'(x_r);
        sin_v = -33'(y_r);
      end
      default: begin
        cos_v = 33'(y_r);
        sin_v = -33'(x_r);
      end
    endcase
  end

  // shared multiplier
  logic signed [31:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [64:0] mul_p;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (ctrl.setup) begin
      mul_a = 32'(({1'b0, cfg.rect_width}) + ({1'b0, cfg.rect_height}));
      mul_b = {17'b0, cfg.arc_ratio};
    end else if (ctrl.angle) begin
      mul_a = {2'b00, quo_r[29:0]};
      mul_b = {2'b00, PI_HALF_Q30};
    end else if (ctrl.mulx) begin
      mul_a = {{(32-DIM_W){1'b0}}, radius_r};
      mul_b = cos_v;
    end else if (ctrl.muly) begin
      mul_a = {{(32-DIM_W){1'b0}}, radius_r};
      mul_b = sin_v;
    end
  end

  assign mul_p = mul_a * mul_b;

  // radius rounding and offset rounding
  logic [39:0]        rsum;
  logic signed [64:0] osum;
  logic signed [25:0] off_v;

  always_comb begin
    rsum  = prod_r[39:0] + 40'd65536;
    osum  = prod_r + 65'sd536870912;
    off_v = osum[55:30];
  end

  // corner centre
  logic signed [DIM_W+1:0] cx, cy, rad_s;

  always_comb begin
    rad_s = $signed({2'b00, radius_r});
    if (corner_r == 2'd0 || corner_r == 2'd3) begin
      cx = $signed({2'b00, cfg.rect_width}) - rad_s;
    end else begin
      cx = rad_s;
    end
    if (corner_r == 2'd0 || corner_r == 2'd1) begin
      cy = $signed({2'b00, cfg.rect_height}) - rad_s;
    end else begin
      cy = rad_s;
    end
  end

  logic signed [SUM_W-1:0] sum_x, sum_y;

  always_comb begin
    sum_x = SUM_W'($signed(cfg.pos_x)) + SUM_W'(cx) + SUM_W'(off_v);
    sum_y = SUM_W'($signed(cfg.pos_y)) + SUM_W'(cy) + SUM_W'(off_v);
  end

  // CORDIC step
  logic [CSTEP_W-1:0] ci;
  logic signed [31:0] dx, dy, at;

  always_comb begin
    ci = ctrl.step[CSTEP_W-1:0];
    dx = y_r >>> ci;
    dy = x_r >>> ci;
    at = atan_q30(ATAN_IDX_W'(ci));
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      idx_r <= in_vertex_index;
    end
    if (ctrl.setup) begin
      corner_r <= corner;
      rem_r    <= (n_ext >= span) ? QUAL_W'(n_ext - span) : n_ext;
      quo_r    <= '0;
    end
    if (ctrl.div) begin
      rem_r    <= rem_nxt;
      quo_r    <= {quo_r[TURN_W-2:0], qbit};
      radius_r <= rsum[39:17];
    end
    if (ctrl.setup || ctrl.angle || ctrl.mulx || ctrl.muly) begin
      prod_r <= mul_p;
    end
    if (ctrl.angle) begin
      quad_r <= quo_r[TURN_W-1:TURN_W-2];
    end
    if (ctrl.cinit) begin
      x_r <= GAIN_Q30;
      y_r <= '0;
      z_r <= $signed({1'b0, prod_r[60:30]});
    end
    if (ctrl.cordic) begin
      if (z_r >= 0) begin
        x_r <= x_r - dx;
        y_r <= y_r + dy;
        z_r <= z_r - at;
      end else begin
        x_r <= x_r + dx;
        y_r <= y_r - dy;
        z_r <= z_r + at;
      end
    end
    if (ctrl.muly) begin
      px_r <= sat_coord(sum_x);
    end
    if (ctrl.setup && setup_err) begin
      out_point_x_r      <= '0;
      out_point_y_r      <= '0;
      out_vertex_color_r <= '0;
      out_status_r       <= err_quality ? STATUS_QUALITY : STATUS_RANGE;
    end else if (ctrl.fin) begin
      out_point_x_r      <= px_r;
      out_point_y_r      <= sat_coord(sum_y);
      out_vertex_color_r <= cfg.fill_color;
      out_status_r       <= STATUS_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (ctrl.setup && setup_err) || ctrl.fin;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_point_x      = out_point_x_r;
  assign out_point_y      = out_point_y_r;
  assign out_vertex_color = out_vertex_color_r;
  assign out_status       = out_status_r;

endmodule

@@ hdl/rounded_rect_outline_points_unit.sv @@
// ----------------------------------------------------------------------------
// Rounded rectangle outline points unit
// A start transfer runs setup, the one-bit-per-cycle turn divider, angle scaling,
// the shared CORDIC stage and the offset products before out_valid is raised.
// Error results (bad quality or index) come from setup, registered onto out_valid.
// No new start is taken until the current item is done; busy is high meanwhile.
// Results are one-cycle strobes; the receiver cannot stall.
// Reset (synchronous, rst_n low): sequencer idle, config to defaults, out_valid low.
// ----------------------------------------------------------------------------
module rounded_rect_outline_points_unit import rrop_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic [IDX_W-1:0]           in_vertex_index,
  output logic                       out_valid,
  output logic signed [COORD_W-1:0]  out_point_x,
  output logic signed [COORD_W-1:0]  out_point_y,
  output logic [COLOR_W-1:0]         out_vertex_color,
  output logic [STATUS_W-1:0]        out_status,
  input  logic                       cfg_we,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_DATA_W-1:0]      cfg_wdata
);

  cfg_t  cfg_r;
  ctrl_t ctrl;
  logic  setup_err;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.quality     <= QUAL_W'(8);
      cfg_r.pos_x       <= '0;
      cfg_r.pos_y       <= '0;
      cfg_r.rect_width  <= '0;
      cfg_r.rect_height <= '0;
      cfg_r.arc_ratio   <= '0;
      cfg_r.fill_color  <= '1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_QUALITY:     cfg_r.quality     <= cfg_wdata[QUAL_W-1:0];
        CFG_POS_X:       cfg_r.pos_x       <= cfg_wdata[COORD_W-1:0];
        CFG_POS_Y:       cfg_r.pos_y       <= cfg_wdata[COORD_W-1:0];
        CFG_RECT_WIDTH:  cfg_r.rect_width  <= cfg_wdata[DIM_W-1:0];
        CFG_RECT_HEIGHT: cfg_r.rect_height <= cfg_wdata[DIM_W-1:0];
        CFG_ARC_RATIO:   cfg_r.arc_ratio   <= cfg_wdata[ARC_W-1:0];
        CFG_FILL_COLOR:  cfg_r.fill_color  <= cfg_wdata[COLOR_W-1:0];
        default: ;
      endcase
    end
  end

  rrop_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .setup_err (setup_err),
    .busy      (busy),
    .ctrl      (ctrl)
  );

  rrop_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .ctrl             (ctrl),
    .cfg              (cfg_r),
    .in_vertex_index  (in_vertex_index),
    .setup_err        (setup_err),
    .out_valid        (out_valid),
    .out_point_x      (out_point_x),
    .out_point_y      (out_point_y),
    .out_vertex_color (out_vertex_color),
    .out_status       (out_status)
  );

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("transfer accepted but unit not busy");

  a_result_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result strobe without work in progress");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("more than one result strobe per item");

  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != STATUS_OK) |->
      (out_point_x == '0 && out_point_y == '0 && out_vertex_color == '0))
    else $error("error result carries non-zero payload");

endmodule
